// File: rtl/adcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcs_pkg
// shared widths, constants, the tick beat type and the millivolt conversion
// ----------------------------------------------------------------------------
package adcs_pkg;

   localparam int CH_W   = 4;
   localparam int RAW_W  = 12;
   localparam int MV_W   = 12;
   localparam int VAL_W  = 18;
   localparam int TICK_W = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLING_ENABLED = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_TICKS     = 4'd1;

   // channels at or above this count are voltmetric
   localparam logic [CH_W:0] MUX_CHANNELS = 5'd16;

   // 3300/4095 reduces to 220/273
   localparam longint FULL_SCALE_MV  = 3300;
   localparam longint FULL_SCALE_RAW = 4095;
   localparam longint MV_GCD         = 15;
   localparam longint MV_NUM         = FULL_SCALE_MV / MV_GCD;
   localparam longint MV_DEN         = FULL_SCALE_RAW / MV_GCD;
   // raw*220 < 2^20 and 273 < 2^9, so a 29 bit reciprocal is exact
   localparam int     MV_SHIFT       = 29;
   localparam longint MV_RECIP       = ((64'd1 << MV_SHIFT) + MV_DEN - 1) / MV_DEN;
   localparam int     PROD_W         = RAW_W + MV_SHIFT;
   localparam logic [PROD_W-1:0] MV_MULT = PROD_W'(MV_RECIP * MV_NUM);

   localparam logic [MV_W-1:0]  ZERO_LOW_MV  = 12'd2200;
   localparam logic [MV_W-1:0]  ZERO_HIGH_MV = 12'd2600;
   localparam logic [VAL_W-1:0] AMP_GAIN     = 18'd10;
   localparam logic [VAL_W-1:0] VOLT_GAIN    = 18'd50;

   typedef struct packed {
      logic [CH_W-1:0]  mux_channel;
      logic [RAW_W-1:0] raw_mux_sample;
      logic [RAW_W-1:0] raw_vdd;
      logic [RAW_W-1:0] raw_vref;
      logic [RAW_W-1:0] raw_vcoil;
   } tick_type;

   // floor(raw * 3300 / 4095) by one constant multiply
   function automatic logic [MV_W-1:0] to_mv(input logic [RAW_W-1:0] raw);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(raw) * MV_MULT;
      return prod[PROD_W-1:MV_SHIFT];
   endfunction

endpackage

// File: rtl/adcs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcs channel interfaces
// tick input, result output and register write channels
// ----------------------------------------------------------------------------
interface adcs_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mux_channel;
   logic [11:0] raw_mux_sample;
   logic [11:0] raw_vdd;
   logic [11:0] raw_vref;
   logic [11:0] raw_vcoil;

   modport source (output valid, mux_channel, raw_mux_sample, raw_vdd, raw_vref,
                   raw_vcoil, input ready);
   modport sink   (input valid, mux_channel, raw_mux_sample, raw_vdd, raw_vref,
                   raw_vcoil, output ready);
endinterface

interface adcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel;
   logic [17:0] mux_value;
   logic [11:0] vdd_mv;
   logic [11:0] vref_mv;
   logic [11:0] vcoil_mv;

   modport source (output valid, channel, mux_value, vdd_mv, vref_mv, vcoil_mv,
                   input ready);
   modport sink   (input valid, channel, mux_value, vdd_mv, vref_mv, vcoil_mv,
                   output ready);
endinterface

interface adcs_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/adcs_tick_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcs_tick_gate
// config registers, tick counter, kept/discarded toggle and input register
// ----------------------------------------------------------------------------
module adcs_tick_gate (
   input  logic             clock,
   input  logic             reset,
   adcs_req_if.sink         req_bus,
   adcs_csr_if.sink         csr_bus,
   output logic             tick_valid,
   output adcs_pkg::tick_type tick_data,
   input  logic             tick_ready
);
   import adcs_pkg::*;

   logic              enable_ff, enable_in;
   logic [TICK_W-1:0] period_ff, period_in;
   logic [TICK_W-1:0] count_ff, count_in;
   logic              skip_ff, skip_in;
   logic              valid_ff, valid_in;
   tick_type          data_ff;

   logic              accept;
   logic              csr_write;
   logic              kept;
   logic [TICK_W-1:0] count_next;

   assign req_bus.ready = !valid_ff || tick_ready;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_write     = csr_bus.valid;
   assign count_next    = count_ff + 1'b1;

   always_comb begin
      enable_in = enable_ff;
      period_in = period_ff;
      count_in  = count_ff;
      skip_in   = skip_ff;
      kept      = 1'b0;
      if (accept && enable_ff && (period_ff != '0)) begin
         if (count_next < period_ff) begin
            count_in = count_next;
         end else begin
            count_in = '0;
            skip_in  = !skip_ff;
            kept     = !skip_ff;
         end
      end
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_SAMPLING_ENABLED: begin
               enable_in = csr_bus.data[0];
               count_in  = '0;
            end
            CSR_PERIOD_TICKS: begin
               period_in = csr_bus.data[TICK_W-1:0];
               count_in  = '0;
            end
            default: ;
         endcase
      end
      valid_in = valid_ff;
      if (accept) begin
         valid_in = kept;
      end else if (tick_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         period_ff <= '0;
         count_ff  <= '0;
         skip_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         skip_ff   <= skip_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && kept) begin
         data_ff.mux_channel    <= req_bus.mux_channel;
         data_ff.raw_mux_sample <= req_bus.raw_mux_sample;
         data_ff.raw_vdd        <= req_bus.raw_vdd;
         data_ff.raw_vref       <= req_bus.raw_vref;
         data_ff.raw_vcoil      <= req_bus.raw_vcoil;
      end
   end

   assign tick_valid = valid_ff;
   assign tick_data  = data_ff;

endmodule

// File: rtl/adcs_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcs_scale
// millivolt conversion, zero capture store and result register
// ----------------------------------------------------------------------------
module adcs_scale #(
   parameter int AMP_CHANNELS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_valid,
   input  adcs_pkg::tick_type tick_data,
   output logic               tick_ready,
   adcs_rsp_if.source         rsp_bus
);
   import adcs_pkg::*;

   localparam int ZIDX_W = (AMP_CHANNELS > 1) ? $clog2(AMP_CHANNELS) : 1;
   localparam logic [CH_W:0] AMP_LIMIT = (CH_W + 1)'(AMP_CHANNELS);

   logic [MV_W-1:0]  zero_ff [AMP_CHANNELS];
   logic             valid_ff, valid_in;
   logic [CH_W-1:0]  channel_ff;
   logic [VAL_W-1:0] value_ff;
   logic [MV_W-1:0]  vdd_ff, vref_ff, vcoil_ff;

   logic              take;
   logic              amp;
   logic [ZIDX_W-1:0] zidx;
   logic [MV_W-1:0]   mv_mux;
   logic [MV_W-1:0]   zero_rd, zero_eff;
   logic              capture, has_zero;
   logic [VAL_W-1:0]  value;

   assign tick_ready = !valid_ff || rsp_bus.ready;
   assign take       = tick_valid && tick_ready;

   assign amp    = ({1'b0, tick_data.mux_channel} < AMP_LIMIT) &&
                   ({1'b0, tick_data.mux_channel} < MUX_CHANNELS);
   assign zidx   = ZIDX_W'(tick_data.mux_channel);
   assign mv_mux = to_mv(tick_data.raw_mux_sample);

   always_comb begin
      zero_rd  = amp ? zero_ff[zidx] : '0;
      capture  = amp && (zero_rd == '0) &&
                 (mv_mux >= ZERO_LOW_MV) && (mv_mux <= ZERO_HIGH_MV);
      zero_eff = capture ? mv_mux : zero_rd;
      has_zero = amp && (zero_eff != '0);
      if (has_zero) begin
         if (mv_mux >= zero_eff) begin
            value = VAL_W'(mv_mux - zero_eff) * AMP_GAIN;
         end else begin
            value = '0;
         end
      end else begin
         value = VAL_W'(mv_mux) * VOLT_GAIN;
      end
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < AMP_CHANNELS; i++) begin
            zero_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         if (take && capture) begin
            zero_ff[zidx] <= mv_mux;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         channel_ff <= tick_data.mux_channel;
         value_ff   <= value;
         vdd_ff     <= to_mv(tick_data.raw_vdd);
         vref_ff    <= to_mv(tick_data.raw_vref);
         vcoil_ff   <= to_mv(tick_data.raw_vcoil);
      end
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.channel   = channel_ff;
   assign rsp_bus.mux_value = value_ff;
   assign rsp_bus.vdd_mv    = vdd_ff;
   assign rsp_bus.vref_mv   = vref_ff;
   assign rsp_bus.vcoil_mv  = vcoil_ff;

endmodule

// File: rtl/adc_tick_sampler_with_zero_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_tick_sampler_with_zero_capture
// picks every period-th tick, keeps every other pick, converts the four
// readings to millivolts and scales an amp channel's mux reading against
// its captured zero
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_bus   in   mux channel, four raw 12 bit readings
//  rsp_bus   out  channel, scaled mux value, three millivolt readings
//  csr_bus   in   register index, write data (0 enable, 1 period)
//
//  one tick beat per cycle while rsp_bus is not stalled; a kept tick loads
//  the input register when accepted and then the result register, from
//  which it can be taken on rsp_bus
//  ticks that are not acquired or are discarded produce no beat
//  stalls on rsp_bus back up through both registers, no beat is dropped
//  synchronous reset clears config, tick counter, toggle and captured zeros
// ----------------------------------------------------------------------------
module adc_tick_sampler_with_zero_capture #(
   parameter int AMP_CHANNELS = 8
) (
   input logic        clock,
   input logic        reset,
   adcs_req_if.sink   req_bus,
   adcs_rsp_if.source rsp_bus,
   adcs_csr_if.sink   csr_bus
);
   import adcs_pkg::*;

   // kept tick handed from the input register to the scaling stage
   logic     tick_valid;
   logic     tick_ready;
   tick_type tick_data;

   // counter, keep/discard toggle and config registers
   adcs_tick_gate u_gate (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .tick_valid (tick_valid),
      .tick_data  (tick_data),
      .tick_ready (tick_ready)
   );

   // conversion, zero capture and result register
   adcs_scale #(
      .AMP_CHANNELS (AMP_CHANNELS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_valid),
      .tick_data  (tick_data),
      .tick_ready (tick_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule
